/* rtl/bba_pkg.sv */
package bba_pkg;

  localparam int TREE_LEVELS    = 7;
  localparam int MIN_BLOCK_LOG2 = 13;
  localparam int REGION_LOG2    = MIN_BLOCK_LOG2 + TREE_LEVELS;
  localparam int NODE_COUNT     = (2 << TREE_LEVELS) - 1;
  localparam int NODE_W         = $clog2(NODE_COUNT);
  localparam int LVL_W          = $clog2(TREE_LEVELS + 2);
  localparam int SH_W           = $clog2(REGION_LOG2 + 1);
  localparam int CNT_W          = TREE_LEVELS + 1;
  localparam int USED_W         = 21;
  localparam int BLK_W          = 8;
  localparam int ADDR_W         = 32;

  localparam logic [ADDR_W:0]   REGION_BYTES = (ADDR_W + 1)'(1) << REGION_LOG2;
  localparam logic [ADDR_W-1:0] BASE_RESET   = 32'h00F0_0000;

  typedef struct packed {
    logic             occ;
    logic             cov;
    logic [CNT_W-1:0] cnt;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOSPACE = 2'd1,
    STS_NOBLOCK = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MARK,
    ST_SUB,
    ST_ANC_UP,
    ST_ANC_RD,
    ST_ANC_WR,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } state_e;

  function automatic logic [NODE_W-1:0] lvl_first(input logic [LVL_W-1:0] lvl);
    return NODE_W'((1 << lvl) - 1);
  endfunction

endpackage

/* rtl/bba_in_if.sv */
interface bba_in_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] request_bytes;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, command, request_bytes, free_address, input ready);
  modport sink (input valid, command, request_bytes, free_address, output ready);
endinterface

/* rtl/bba_out_if.sv */
interface bba_out_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] block_address;
  logic [USED_W-1:0] used_bytes;
  logic [BLK_W-1:0]  blocks_used;

  modport source (output valid, status, block_address, used_bytes, blocks_used, input ready);
  modport sink (input valid, status, block_address, used_bytes, blocks_used, output ready);
endinterface

/* rtl/bba_ram.sv */
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/buddy_block_allocator_top.sv */
// channel | dir | handshake     | payload
// in_i    | in  | valid / ready | command, request_bytes, free_address
// out_o   | out | valid / ready | status, block_address, used_bytes, blocks_used
// cfg     | in  | cfg_we_i      | cfg_wdata_i (base_address)
// one item at a time; ready only while idle
// allocate: a read and a check per node of the level scan, a write per subtree node,
// a read and a write per ancestor, all through the single port of the node table
// free: a read and a check per level of the upward walk, then subtree and ancestors
// after reset a clearing pass sweeps all 255 entries of the node table
// a waiting result holds the sequencer until out_o is taken
module buddy_block_allocator_top
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  bba_in_if.sink            in_i,
  bba_out_if.source         out_o
);
  state_e             state_q, state_d;
  logic [NODE_W-1:0]  node_q, node_d;
  logic [LVL_W-1:0]   d_q, d_d, e_q, e_d;
  logic [NODE_W-1:0]  k_q, k_d;
  logic               free_q, free_d;
  logic [USED_W-1:0]  size_q, size_d;
  logic [USED_W-1:0]  off_q, off_d;
  status_e            sts_q, sts_d;
  logic [ADDR_W-1:0]  baddr_q, baddr_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [BLK_W-1:0]   blk_q, blk_d;
  logic [ADDR_W-1:0]  base_q;
  logic               out_valid_q, load_out;

  logic               ram_we;
  logic [NODE_W-1:0]  ram_addr;
  node_t              ram_wdata, ram_rdata;

  logic [NODE_W-1:0]  pos;
  logic [NODE_W-1:0]  span_m1;
  logic [LVL_W-1:0]   jsel;
  logic [ADDR_W-1:0]  off_full;
  logic [USED_W-1:0]  start;
  logic [CNT_W-1:0]   cnt_dec;

  bba_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_COUNT)) u_nodes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      node_q      <= '0;
      d_q         <= '0;
      e_q         <= '0;
      k_q         <= '0;
      free_q      <= 1'b0;
      sts_q       <= STS_OK;
      used_q      <= '0;
      blk_q       <= '0;
      base_q      <= BASE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      d_q     <= d_d;
      e_q     <= e_d;
      k_q     <= k_d;
      free_q  <= free_d;
      sts_q   <= sts_d;
      used_q  <= used_d;
      blk_q   <= blk_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    off_q   <= off_d;
    baddr_q <= baddr_d;
    if (load_out) begin
      out_o.status        <= sts_q;
      out_o.block_address <= baddr_q;
      out_o.used_bytes    <= used_q;
      out_o.blocks_used   <= blk_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign in_i.ready  = (state_q == ST_IDLE);

  assign pos      = node_q - lvl_first(d_q);
  assign span_m1  = NODE_W'((1 << (e_q - d_q)) - 1);
  assign off_full = in_i.free_address - base_q;
  assign start    = USED_W'(pos) << (SH_W'(REGION_LOG2) - SH_W'(d_q));
  assign cnt_dec  = (ram_rdata.cnt != '0) ? ram_rdata.cnt - CNT_W'(1) : '0;

  always_comb begin
    jsel = LVL_W'(TREE_LEVELS);
    for (int j = TREE_LEVELS; j >= 0; j--) begin
      if ({1'b0, in_i.request_bytes} <= ((ADDR_W + 1)'(1) << (MIN_BLOCK_LOG2 + j))) begin
        jsel = LVL_W'(j);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    node_d    = node_q;
    d_d       = d_q;
    e_d       = e_q;
    k_d       = k_q;
    free_d    = free_q;
    size_d    = size_q;
    off_d     = off_q;
    sts_d     = sts_q;
    baddr_d   = baddr_q;
    used_d    = used_q;
    blk_d     = blk_q;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = node_q;
    ram_wdata = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = k_q;
        k_d      = k_q + NODE_W'(1);
        if (k_q == NODE_W'(NODE_COUNT - 1)) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          free_d  = (in_i.command == CMD_FREE);
          sts_d   = STS_OK;
          baddr_d = '0;
          k_d     = '0;
          if (in_i.command == CMD_ALLOC) begin
            if ({1'b0, in_i.request_bytes} > REGION_BYTES) begin
              sts_d   = STS_NOSPACE;
              state_d = ST_DONE;
            end else begin
              d_d     = LVL_W'(TREE_LEVELS) - jsel;
              size_d  = USED_W'(1) << (SH_W'(MIN_BLOCK_LOG2) + SH_W'(jsel));
              state_d = ST_SCAN_RD;
            end
          end else if (in_i.free_address == '0) begin
            state_d = ST_DONE;
          end else if ({1'b0, off_full} >= REGION_BYTES) begin
            sts_d   = STS_NOBLOCK;
            state_d = ST_DONE;
          end else begin
            off_d   = USED_W'(off_full);
            node_d  = lvl_first(LVL_W'(TREE_LEVELS))
                      + NODE_W'(off_full[REGION_LOG2-1:MIN_BLOCK_LOG2]);
            d_d     = LVL_W'(TREE_LEVELS);
            state_d = ST_WALK_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        ram_addr = lvl_first(d_q) + k_q;
        state_d  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!ram_rdata.occ) begin
          node_d  = lvl_first(d_q) + k_q;
          baddr_d = base_q + (ADDR_W'(k_q) << (SH_W'(REGION_LOG2) - SH_W'(d_q)));
          state_d = ST_MARK;
        end else if (k_q == NODE_W'((1 << d_q) - 1)) begin
          sts_d   = STS_NOSPACE;
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + NODE_W'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_MARK: begin
        ram_we        = 1'b1;
        ram_wdata.occ = !free_q;
        e_d           = d_q + LVL_W'(1);
        k_d           = '0;
        state_d       = (d_q == LVL_W'(TREE_LEVELS)) ? ST_ANC_UP : ST_SUB;
      end
      ST_SUB: begin
        ram_we        = 1'b1;
        ram_addr      = lvl_first(e_q) + (pos << (e_q - d_q)) + k_q;
        ram_wdata.occ = !free_q;
        ram_wdata.cov = !free_q;
        k_d           = k_q + NODE_W'(1);
        if (k_q == span_m1) begin
          k_d = '0;
          e_d = e_q + LVL_W'(1);
          if (e_q == LVL_W'(TREE_LEVELS)) begin
            state_d = ST_ANC_UP;
          end
        end
      end
      ST_ANC_UP: begin
        if (node_q == '0) begin
          if (free_q) begin
            used_d = (used_q >= size_q) ? used_q - size_q : '0;
            blk_d  = (blk_q != '0) ? blk_q - BLK_W'(1) : '0;
          end else begin
            used_d = used_q + size_q;
            blk_d  = blk_q + BLK_W'(1);
          end
          state_d = ST_DONE;
        end else begin
          node_d  = (node_q - NODE_W'(1)) >> 1;
          state_d = ST_ANC_RD;
        end
      end
      ST_ANC_RD: begin
        state_d = ST_ANC_WR;
      end
      ST_ANC_WR: begin
        ram_we = 1'b1;
        ram_wdata.cov = ram_rdata.cov;
        if (free_q) begin
          ram_wdata.cnt = cnt_dec;
          ram_wdata.occ = (cnt_dec == '0) ? 1'b0 : ram_rdata.occ;
        end else begin
          ram_wdata.cnt = ram_rdata.cnt + CNT_W'(1);
          ram_wdata.occ = 1'b1;
        end
        state_d = ST_ANC_UP;
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (ram_rdata.occ && !ram_rdata.cov && ram_rdata.cnt == '0) begin
          if (start == off_q) begin
            size_d  = USED_W'(1) << (SH_W'(REGION_LOG2) - SH_W'(d_q));
            state_d = ST_MARK;
          end else begin
            sts_d   = STS_NOBLOCK;
            state_d = ST_DONE;
          end
        end else if (node_q == '0) begin
          sts_d   = STS_NOBLOCK;
          state_d = ST_DONE;
        end else begin
          node_d  = (node_q - NODE_W'(1)) >> 1;
          d_d     = d_q - LVL_W'(1);
          state_d = ST_WALK_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_q <= BLK_W'(1 << TREE_LEVELS))
    else $error("block count above leaf count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_q == '0 |-> used_q == '0)
    else $error("bytes in use with no blocks");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_CHK |-> k_q <= NODE_W'((1 << d_q) - 1))
    else $error("scan beyond level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_o.valid && $past(state_q) == ST_DONE)
    else $error("result loaded outside done");
endmodule
